// ===== hdl/adam_optimizer_step_macros.svh =====
// ----------------------------------------------------------------------------
// Adam optimizer step: assertion macros
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_STEP_MACROS_SVH
`define ADAM_OPTIMIZER_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define ADOS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ADOS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ADOS_ASSERT_IMP(label, clk, rst, ante, cons)
`define ADOS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/ados_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer step: shared package
// Constants, register codes, state encoding and iterative unit interface.
// ----------------------------------------------------------------------------
package ados_pkg;

  localparam int NUM_PARAMS_DEF = 1024;
  localparam int IDX_W          = 10;

  localparam logic [31:0] STEP_SIZE_RST = 32'd66;
  localparam logic [15:0] BETA_ONE_RST  = 16'd58982;
  localparam logic [15:0] BETA_TWO_RST  = 16'd65470;
  localparam logic [15:0] EPSILON_RST   = 16'd1;
  localparam logic [31:0] POWER_ONE     = 32'h8000_0000;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_BETA_ONE  = 2'd1,
    REG_BETA_TWO  = 2'd2,
    REG_EPSILON   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [63:0] operand;
    logic [31:0] divisor;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [32:0] result;
  } iter_rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_POW1, S_POW2, S_POW3, S_READ, S_LOAD, S_M2, S_M3,
    S_V1, S_V2, S_V3, S_V4, S_DIVM, S_WAITM, S_DIVV, S_WAITV, S_SQRT,
    S_WAITS, S_NUM1, S_NUM2, S_DIVF, S_WAITF, S_OUT
  } state_t;

endpackage

// ===== hdl/adam_optimizer_step.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer step engine
// Element-wise Adam update in fixed point with moment stores in RAM.
//
//   Channel  Handshake              Beat contents
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//   in       in_valid/in_ready      command, element_index, gradient
//   out      out_valid/out_ready    update, result_index
//
// A step beat runs up to three 33-step divides and a 24-step square root on the
// one shared compare-subtract unit; index 0 first updates the beta powers,
// and a division whose quotient overflows ends early.
// After reset and after every reset command, a clearing pass over all
// NUM_PARAMS entries zeroes both moment RAMs; in_ready stays low meanwhile.
// One item is in flight at a time; out holds until out_ready.
// ----------------------------------------------------------------------------
module adam_optimizer_step #(
  parameter int NUM_PARAMS = ados_pkg::NUM_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [ados_pkg::IDX_W-1:0] element_index,
  input  logic signed [31:0] gradient,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] update,
  output logic [ados_pkg::IDX_W-1:0] result_index
);

  `include "adam_optimizer_step_macros.svh"

  localparam int AW    = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int CMP_W = 18;

  ados_pkg::state_t state, state_next;

  logic [31:0] step_size;
  logic [15:0] beta_one;
  logic [15:0] beta_two;
  logic [15:0] epsilon;
  logic [31:0] pow1;
  logic [31:0] pow2;

  logic [AW-1:0]              clr_addr;
  logic                       clr_reply;
  logic [ados_pkg::IDX_W-1:0] idx_r;
  logic                       in_range_r;
  logic signed [31:0]         grad_r;
  logic [31:0]                vold;
  logic signed [65:0]         prod;
  logic signed [65:0]         acc;
  logic [46:0]                g2;
  logic signed [31:0]         mnew;
  logic [31:0]                vnew;
  logic                       neg;
  logic [31:0]                mmag;
  logic [31:0]                mh;
  logic [31:0]                vh;
  logic [24:0]                den;
  logic [63:0]                num;
  logic [31:0]                upd;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] addr;
  logic [31:0]   m_wdata;
  logic [31:0]   v_wdata;
  logic [31:0]   m_rdata;
  logic [31:0]   v_rdata;

  ados_pkg::iter_req_t iter_req;
  ados_pkg::iter_rsp_t iter_rsp;

  logic [16:0]        k1;
  logic [16:0]        k2;
  logic [31:0]        gmag;
  logic [31:0]        d1;
  logic [31:0]        d2;
  logic signed [65:0] msum;
  logic signed [65:0] msh;
  logic signed [31:0] m_sat;
  logic signed [65:0] vsum;
  logic [31:0]        v_sat;
  logic               in_range;
  logic               iter_wait;
  logic               pow_ok;

  // saturated magnitude for a signed 32-bit result
  function automatic logic [31:0] sat_mag(input logic s, input logic huge,
                                          input logic [32:0] mag);
    logic [31:0] r;
    if (s) begin
      r = (huge || mag > 33'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
    end else begin
      r = (huge || mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  ados_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_first_moment (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(m_wdata),
    .raddr(addr), .rdata(m_rdata)
  );

  ados_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_second_moment (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(v_wdata),
    .raddr(addr), .rdata(v_rdata)
  );

  ados_iter u_iter (
    .clk(clk), .rst(rst), .req(iter_req), .rsp(iter_rsp)
  );

  assign addr      = AW'(idx_r);
  assign in_range  = (CMP_W'(element_index) < CMP_W'(NUM_PARAMS));
  assign k1        = 17'h1_0000 - {1'b0, beta_one};
  assign k2        = 17'h1_0000 - {1'b0, beta_two};
  assign gmag      = grad_r[31] ? (32'd0 - grad_r) : grad_r;
  assign d1        = ados_pkg::POWER_ONE - pow1;
  assign d2        = ados_pkg::POWER_ONE - pow2;
  assign msum      = acc + prod;
  assign msh       = msum >>> 16;
  assign m_sat     = (msh > 66'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (msh < -66'sh8000_0000) ? -32'sh8000_0000 : msh[31:0];
  assign vsum      = acc + (prod <<< 32);
  assign v_sat     = (|vsum[65:48]) ? 32'hFFFF_FFFF : vsum[47:16];

  assign iter_wait = (state == ados_pkg::S_WAITM) || (state == ados_pkg::S_WAITV) ||
                     (state == ados_pkg::S_WAITS) || (state == ados_pkg::S_WAITF);
  assign pow_ok    = (pow1 <= ados_pkg::POWER_ONE) && (pow2 <= ados_pkg::POWER_ONE);

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state == ados_pkg::S_IDLE);
  assign out_valid    = (state == ados_pkg::S_OUT);
  assign update       = upd;
  assign result_index = idx_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ados_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    mul_a            = '0;
    mul_b            = '0;
    ram_we           = 1'b0;
    ram_waddr        = addr;
    m_wdata          = m_sat;
    v_wdata          = v_sat;
    iter_req.start   = 1'b0;
    iter_req.op      = ados_pkg::OP_DIV;
    iter_req.operand = {1'b0, mmag, 31'b0};
    iter_req.divisor = d1;
    unique case (state)
      ados_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        m_wdata   = '0;
        v_wdata   = '0;
        if (clr_addr == AW'(NUM_PARAMS - 1)) begin
          state_next = clr_reply ? ados_pkg::S_OUT : ados_pkg::S_IDLE;
        end
      end
      ados_pkg::S_IDLE: begin
        if (in_valid) begin
          if (command == ados_pkg::CMD_CLEAR) begin
            state_next = ados_pkg::S_CLEAR;
          end else if (element_index == '0) begin
            state_next = ados_pkg::S_POW1;
          end else begin
            state_next = in_range ? ados_pkg::S_READ : ados_pkg::S_OUT;
          end
        end
      end
      ados_pkg::S_POW1: begin
        mul_a      = {1'b0, pow1};
        mul_b      = {17'b0, beta_one};
        state_next = ados_pkg::S_POW2;
      end
      ados_pkg::S_POW2: begin
        mul_a      = {1'b0, pow2};
        mul_b      = {17'b0, beta_two};
        state_next = ados_pkg::S_POW3;
      end
      ados_pkg::S_POW3: begin
        state_next = in_range_r ? ados_pkg::S_READ : ados_pkg::S_OUT;
      end
      ados_pkg::S_READ: state_next = ados_pkg::S_LOAD;
      ados_pkg::S_LOAD: begin
        mul_a      = {17'b0, beta_one};
        mul_b      = {m_rdata[31], m_rdata};
        state_next = ados_pkg::S_M2;
      end
      ados_pkg::S_M2: begin
        mul_a      = {16'b0, k1};
        mul_b      = {grad_r[31], grad_r};
        state_next = ados_pkg::S_M3;
      end
      ados_pkg::S_M3: begin
        mul_a      = {1'b0, gmag};
        mul_b      = {1'b0, gmag};
        state_next = ados_pkg::S_V1;
      end
      ados_pkg::S_V1: begin
        mul_a      = {17'b0, beta_two};
        mul_b      = {1'b0, vold};
        state_next = ados_pkg::S_V2;
      end
      ados_pkg::S_V2: begin
        mul_a      = {16'b0, k2};
        mul_b      = {1'b0, g2[31:0]};
        state_next = ados_pkg::S_V3;
      end
      ados_pkg::S_V3: begin
        mul_a      = {16'b0, k2};
        mul_b      = {18'b0, g2[46:32]};
        state_next = ados_pkg::S_V4;
      end
      ados_pkg::S_V4: begin
        ram_we     = 1'b1;
        m_wdata    = mnew;
        state_next = ados_pkg::S_DIVM;
      end
      ados_pkg::S_DIVM: begin
        if (d1 == '0) begin
          state_next = ados_pkg::S_DIVV;
        end else begin
          iter_req.start = 1'b1;
          state_next     = ados_pkg::S_WAITM;
        end
      end
      ados_pkg::S_WAITM: begin
        if (iter_rsp.done) state_next = ados_pkg::S_DIVV;
      end
      ados_pkg::S_DIVV: begin
        iter_req.operand = {1'b0, vnew, 31'b0};
        iter_req.divisor = d2;
        if (d2 == '0) begin
          state_next = ados_pkg::S_SQRT;
        end else begin
          iter_req.start = 1'b1;
          state_next     = ados_pkg::S_WAITV;
        end
      end
      ados_pkg::S_WAITV: begin
        if (iter_rsp.done) state_next = ados_pkg::S_SQRT;
      end
      ados_pkg::S_SQRT: begin
        iter_req.start   = 1'b1;
        iter_req.op      = ados_pkg::OP_SQRT;
        iter_req.operand = {16'b0, vh, 16'b0};
        state_next       = ados_pkg::S_WAITS;
      end
      ados_pkg::S_WAITS: begin
        if (iter_rsp.done) state_next = ados_pkg::S_NUM1;
      end
      ados_pkg::S_NUM1: begin
        mul_a      = {1'b0, step_size};
        mul_b      = {1'b0, mh};
        state_next = ados_pkg::S_NUM2;
      end
      ados_pkg::S_NUM2: state_next = ados_pkg::S_DIVF;
      ados_pkg::S_DIVF: begin
        iter_req.operand = num;
        iter_req.divisor = {7'b0, den};
        if (den == '0) begin
          state_next = ados_pkg::S_OUT;
        end else begin
          iter_req.start = 1'b1;
          state_next     = ados_pkg::S_WAITF;
        end
      end
      ados_pkg::S_WAITF: begin
        if (iter_rsp.done) state_next = ados_pkg::S_OUT;
      end
      ados_pkg::S_OUT: begin
        if (out_ready) state_next = ados_pkg::S_IDLE;
      end
      default: state_next = ados_pkg::S_IDLE;
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= ados_pkg::STEP_SIZE_RST;
      beta_one  <= ados_pkg::BETA_ONE_RST;
      beta_two  <= ados_pkg::BETA_TWO_RST;
      epsilon   <= ados_pkg::EPSILON_RST;
      pow1      <= ados_pkg::POWER_ONE;
      pow2      <= ados_pkg::POWER_ONE;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (ados_pkg::reg_idx_t'(cfg_index))
          ados_pkg::REG_STEP_SIZE: step_size <= cfg_data;
          ados_pkg::REG_BETA_ONE:  beta_one  <= cfg_data[15:0];
          ados_pkg::REG_BETA_TWO:  beta_two  <= cfg_data[15:0];
          ados_pkg::REG_EPSILON:   epsilon   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == ados_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ados_pkg::S_IDLE && in_valid) begin
        clr_addr  <= '0;
        clr_reply <= 1'b1;
        if (command == ados_pkg::CMD_CLEAR) begin
          beta_one <= ados_pkg::BETA_ONE_RST;
          beta_two <= ados_pkg::BETA_TWO_RST;
          pow1     <= ados_pkg::POWER_ONE;
          pow2     <= ados_pkg::POWER_ONE;
        end
      end
      if (state == ados_pkg::S_POW2) pow1 <= prod[47:16];
      if (state == ados_pkg::S_POW3) pow2 <= prod[47:16];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ados_pkg::S_IDLE: begin
        idx_r      <= element_index;
        grad_r     <= gradient;
        in_range_r <= in_range;
        upd        <= '0;
      end
      ados_pkg::S_LOAD: vold <= v_rdata;
      ados_pkg::S_M2:   acc  <= prod;
      ados_pkg::S_M3:   mnew <= m_sat;
      ados_pkg::S_V1:   g2   <= prod[62:16];
      ados_pkg::S_V2:   acc  <= prod;
      ados_pkg::S_V3:   acc  <= acc + prod;
      ados_pkg::S_V4: begin
        vnew <= v_sat;
        neg  <= mnew[31];
        mmag <= mnew[31] ? (32'd0 - mnew) : mnew;
      end
      ados_pkg::S_DIVM: begin
        if (d1 == '0) mh <= sat_mag(neg, 1'b0, {1'b0, mmag});
      end
      ados_pkg::S_WAITM: begin
        if (iter_rsp.done) mh <= sat_mag(neg, iter_rsp.sat, iter_rsp.result);
      end
      ados_pkg::S_DIVV: begin
        if (d2 == '0) vh <= vnew;
      end
      ados_pkg::S_WAITV: begin
        if (iter_rsp.done) begin
          vh <= (iter_rsp.sat || iter_rsp.result[32]) ? 32'hFFFF_FFFF
                                                      : iter_rsp.result[31:0];
        end
      end
      ados_pkg::S_WAITS: begin
        if (iter_rsp.done) den <= {1'b0, iter_rsp.result[23:0]} + {9'b0, epsilon};
      end
      ados_pkg::S_NUM2: num <= prod[63:0];
      ados_pkg::S_DIVF: begin
        // zero denominator: saturate toward the sign unless the numerator is zero
        if (den == '0 && num != '0) begin
          upd <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
      ados_pkg::S_WAITF: begin
        if (iter_rsp.done) begin
          upd <= neg ? (32'd0 - sat_mag(neg, iter_rsp.sat, iter_rsp.result))
                     : sat_mag(neg, iter_rsp.sat, iter_rsp.result);
        end
      end
      default: ;
    endcase
  end

  `ADOS_ASSERT_NXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)
  `ADOS_ASSERT_IMP(a_one_in_flight, clk, rst, in_ready, !out_valid)
  `ADOS_ASSERT_IMP(a_power_bound, clk, rst, 1'b1, pow_ok)
  `ADOS_ASSERT_IMP(a_iter_done_waited, clk, rst, iter_rsp.done, iter_wait)

endmodule

// ===== hdl/ados_ram.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer step: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ados_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ados_iter.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer step: iterative divide / square root unit
// One compare-subtract per cycle: restoring divide with a 33-bit quotient
// and early overflow detect, or a 24-step square root of a 48-bit value.
// ----------------------------------------------------------------------------
module ados_iter (
  input  logic                clk,
  input  logic                rst,
  input  ados_pkg::iter_req_t req,
  output ados_pkg::iter_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic               sat;
  ados_pkg::iter_op_t op;
  logic [63:0]        sh;
  logic [33:0]        rem;
  logic [32:0]        quo;
  logic [31:0]        dvs;
  logic [5:0]         cnt;

  logic [33:0] rp;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    if (op == ados_pkg::OP_DIV) begin
      rp    = {rem[32:0], sh[63]};
      trial = {2'b00, dvs};
    end else begin
      rp    = {rem[31:0], sh[63:62]};
      trial = {8'b0, quo[23:0], 2'b01};
    end
    ge   = (rp >= trial);
    diff = rp - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op  <= req.op;
        quo <= '0;
        sat <= 1'b0;
        dvs <= req.divisor;
        if (req.op == ados_pkg::OP_DIV) begin
          rem <= {3'b000, req.operand[63:33]};
          sh  <= {req.operand[32:0], 31'b0};
          cnt <= 6'd32;
          // quotient needs more than 33 bits: report overflow at once
          if ({1'b0, req.operand[63:33]} >= req.divisor) begin
            sat  <= 1'b1;
            done <= 1'b1;
          end else begin
            busy <= 1'b1;
          end
        end else begin
          rem  <= '0;
          sh   <= {req.operand[47:0], 16'b0};
          cnt  <= 6'd23;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? diff : rp;
        quo <= {quo[31:0], ge};
        sh  <= (op == ados_pkg::OP_DIV) ? {sh[62:0], 1'b0} : {sh[61:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.sat    = sat;
  assign rsp.result = quo;

endmodule

// ===== tb/sv/adam_optimizer_step_test.sv =====
// ----------------------------------------------------------------------------
// Adam optimizer step: self-checking testbench
// Drives step and reset commands with random gaps and output stalls, predicts
// each update from a bit-accurate model of the fixed-point Adam arithmetic,
// and checks every result beat in order. Registers change only while idle.
// ----------------------------------------------------------------------------
module adam_optimizer_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAR = ados_pkg::NUM_PARAMS_DEF;
  localparam int IW   = ados_pkg::IDX_W;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic signed [31:0] update;
    logic [IW-1:0]      index;
  } adam_result_t;

  class update_scoreboard;
    logic [31:0] alpha;
    logic [15:0] b1, b2, eps;
    logic signed [31:0] mom1 [NPAR];
    logic [31:0] mom2 [NPAR];
    logic [31:0] pow1, pow2;
    adam_result_t pending_updates[$];
    int mismatches;
    int errors;

    function void clear_moments();
      for (int k = 0; k < NPAR; k++) begin
        mom1[k] = '0;
        mom2[k] = '0;
      end
      pow1 = ados_pkg::POWER_ONE;
      pow2 = ados_pkg::POWER_ONE;
    endfunction

    function void power_on();
      alpha = ados_pkg::STEP_SIZE_RST;
      b1 = ados_pkg::BETA_ONE_RST;
      b2 = ados_pkg::BETA_TWO_RST;
      eps = ados_pkg::EPSILON_RST;
      clear_moments();
    endfunction

    function void write_reg(ados_pkg::reg_idx_t r, logic [31:0] d);
      case (r)
        ados_pkg::REG_STEP_SIZE: alpha = d;
        ados_pkg::REG_BETA_ONE:  b1 = d[15:0];
        ados_pkg::REG_BETA_TWO:  b2 = d[15:0];
        ados_pkg::REG_EPSILON:   eps = d[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= r + bitv) begin
          x = x - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    function logic [31:0] clamp_signed(bit neg, logic [63:0] mag);
      if (neg) begin
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
    endfunction

    function void note_input(logic cmd, logic [IW-1:0] idx, logic signed [31:0] g);
      adam_result_t res;
      longint signed m, gs;
      logic [63:0] gmag, g2, v, d1, d2, mmag, mh, vh, den, num;
      bit neg;
      res.index = idx;
      res.update = '0;
      if (cmd == ados_pkg::CMD_CLEAR) begin
        clear_moments();
        b1 = ados_pkg::BETA_ONE_RST;
        b2 = ados_pkg::BETA_TWO_RST;
        pending_updates.push_back(res);
        return;
      end
      if (idx == 0) begin
        pow1 = (64'(pow1) * 64'(b1)) >> 16;
        pow2 = (64'(pow2) * 64'(b2)) >> 16;
      end
      if (int'(idx) < NPAR) begin
        gs = g;
        // arithmetic shift gives floor division by 2^16
        m = (longint'(b1) * longint'(mom1[idx]) + (65536 - longint'(b1)) * gs) >>> 16;
        gmag = gs < 0 ? -gs : gs;
        g2 = (gmag * gmag) >> 16;
        v = (64'(b2) * 64'(mom2[idx]) + (64'd65536 - 64'(b2)) * g2) >> 16;
        d1 = 64'h8000_0000 - 64'(pow1);
        d2 = 64'h8000_0000 - 64'(pow2);
        if (m > 64'sd2147483647) m = 2147483647;
        if (m < -64'sd2147483648) m = -2147483648;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        mom1[idx] = m[31:0];
        mom2[idx] = v[31:0];
        neg = m < 0;
        mmag = neg ? -m : m;
        mh = (d1 == 0) ? mmag : (mmag << 31) / d1;
        if (neg) begin
          if (mh > 64'h8000_0000) mh = 64'h8000_0000;
        end else if (mh > 64'h7FFF_FFFF) begin
          mh = 64'h7FFF_FFFF;
        end
        vh = (d2 == 0) ? v : (v << 31) / d2;
        if (vh > 64'hFFFF_FFFF) vh = 64'hFFFF_FFFF;
        den = int_sqrt(vh << 16) + 64'(eps);
        num = 64'(alpha) * mh;
        if (den == 0)
          res.update = (num == 0) ? 32'd0 : clamp_signed(neg, '1);
        else
          res.update = clamp_signed(neg, num / den);
      end
      pending_updates.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] upd, logic [IW-1:0] idx);
      adam_result_t exp_r;
      if (pending_updates.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result beat: update=%h index=%0d", upd, idx);
        return;
      end
      exp_r = pending_updates.pop_front();
      if (upd !== exp_r.update || idx !== exp_r.index) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: expected update=%h index=%0d, got update=%h index=%0d",
                   exp_r.update, exp_r.index, upd, idx);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [IW-1:0] element_index = '0;
  logic signed [31:0] gradient = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] update;
  logic [IW-1:0] result_index;

  update_scoreboard sb = new();
  longint cycles = 0;
  int hold_off = 0;
  int vec_len = 8;

  always #5 clk = ~clk;

  adam_optimizer_step dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_result(update, result_index);

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // valid stays up across a zero gap; drop it only when idling
  task automatic send_item(logic cmd, logic [IW-1:0] idx, logic signed [31:0] g,
                           bit nogap = 0);
    int w;
    w = nogap ? 0 : $urandom_range(0, 11);
    cfg_valid <= 1'b0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    element_index <= idx;
    gradient <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, idx, g);
    @(negedge clk);
  endtask

  task automatic write_reg(ados_pkg::reg_idx_t r, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(r, d);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_updates.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
    endcase
  endfunction

  // well-formed vectors 0..n-1 with random gradients, a few stray indices and clears
  task automatic run_vectors(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      for (int k = 0; k < vec_len && sent < items; k++) begin
        send_item(ados_pkg::CMD_STEP, IW'(k), rand_grad());
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(ados_pkg::CMD_STEP, IW'($urandom_range(0, NPAR - 1)), rand_grad());
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        send_item(ados_pkg::CMD_CLEAR, IW'($urandom()), $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    sb.power_on();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed extremes: stray first index, full-scale gradients, top index
    send_item(ados_pkg::CMD_STEP, 10'd5, 32'sh7FFF_FFFF);
    send_item(ados_pkg::CMD_STEP, 10'd0, 32'sh8000_0000);
    send_item(ados_pkg::CMD_STEP, 10'd0, 32'sh7FFF_FFFF);
    send_item(ados_pkg::CMD_STEP, 10'd1023, 32'sh0001_0000);
    send_item(ados_pkg::CMD_STEP, 10'd1, -32'sh0001_0000);
    send_item(ados_pkg::CMD_STEP, 10'd2, 32'sh0);
    send_item(ados_pkg::CMD_STEP, 10'd1023, 32'shFFFF_FFFF);
    send_item(ados_pkg::CMD_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
    send_item(ados_pkg::CMD_STEP, 10'd3, 32'sh0000_0001);
    send_item(ados_pkg::CMD_CLEAR, 10'd0, 32'sh0);
    drain();

    // zero epsilon with zero gradient: zero denominator case
    write_reg(ados_pkg::REG_EPSILON, 32'd0);
    write_reg(ados_pkg::REG_STEP_SIZE, 32'hFFFF_FFFF);
    send_item(ados_pkg::CMD_STEP, 10'd0, 32'sh0);
    send_item(ados_pkg::CMD_STEP, 10'd1, 32'sh0000_0100);
    send_item(ados_pkg::CMD_STEP, 10'd2, -32'sh0000_0100);
    drain();
    // betas at extremes; zero beta drops its power to zero at once
    write_reg(ados_pkg::REG_BETA_ONE, 32'h0000_FFFF);
    write_reg(ados_pkg::REG_BETA_TWO, 32'd0);
    write_reg(ados_pkg::REG_EPSILON, 32'h0000_FFFF);
    write_reg(ados_pkg::REG_STEP_SIZE, 32'd0);
    send_item(ados_pkg::CMD_STEP, 10'd0, 32'sh0005_0000);
    send_item(ados_pkg::CMD_STEP, 10'd4, -32'sh0005_0000);
    drain();
    write_reg(ados_pkg::REG_STEP_SIZE, 32'h0001_0000);
    send_item(ados_pkg::CMD_STEP, 10'd0, 32'sh0005_0000);
    send_item(ados_pkg::CMD_STEP, 10'd4, -32'sh0005_0000);
    drain();

    // random phases across several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ados_pkg::REG_STEP_SIZE,
                ph == 5 ? 32'hFFFF_FFFF : $urandom_range(1, 32'h0004_0000));
      write_reg(ados_pkg::REG_BETA_ONE, ph == 4 ? 32'd0 : $urandom_range(40000, 65535));
      write_reg(ados_pkg::REG_BETA_TWO, ph == 4 ? 32'hFFFF : $urandom_range(60000, 65535));
      write_reg(ados_pkg::REG_EPSILON, $urandom_range(0, 65535));
      vec_len = $urandom_range(2, 12);
      if (ph == 2) begin
        // long output hold-off while inputs keep coming without gaps
        hold_off = 600;
        for (int k = 0; k < 6; k++) send_item(ados_pkg::CMD_STEP, IW'(k), rand_grad(), 1);
      end
      run_vectors(300);
      drain();
    end

    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
